### rtl/core/tpspwm_pkg.sv
// tpspwm_pkg: shared types and constants for the three-phase sine pwm compare block
// holds the quarter-wave sine rom contents and configuration register indexes
// no dependencies
package tpspwm_pkg;

  localparam int unsigned MOD_W    = 18;
  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned IN_W     = 12;
  localparam int unsigned CMP_W    = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned SINE_W   = 15;
  localparam int unsigned ROM_DEPTH = 65;
  localparam int unsigned ROM_IDX_W = 7;
  localparam int unsigned NPHASE   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODULATION    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNTS = 1'b1;

  localparam logic [MOD_W-1:0]    MODULATION_RST = 18'd19661;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 17'd65536;
  localparam logic [PERIOD_W-1:0] FULL_SCALE     = 17'd65536;

  typedef logic [SINE_W-1:0] sine_t;
  typedef sine_t rom_t [ROM_DEPTH];

  localparam rom_t QUARTER_SINE = '{
    15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
    15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
    15'd12540, 15'd13279, 15'd14010, 15'd14732, 15'd15447, 15'd16151, 15'd16846, 15'd17530,
    15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
    15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
    15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
    15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
    15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
    15'd32767
  };

endpackage

### rtl/core/three_phase_sine_pwm_compare.sv
// three_phase_sine_pwm_compare: angle in, three pwm compare counts out (u, v, w)
// depends on tpspwm_pkg for the sine rom and register indexes
// an accepted word (start high, busy low) passes to its out_valid strobe through
// one register after each of rom read, interpolation, modulation, saturation, period scale
// one word per cycle in while busy is low, one result per cycle out; receiver cannot stall
// reset restores modulation and period, drops words in flight; busy is a registered !rst_n
module three_phase_sine_pwm_compare #(
  parameter int unsigned ANGLE_BITS         = 12,
  parameter int unsigned SINE_FRACTION_BITS = 15
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [tpspwm_pkg::IN_W-1:0]           in_angle,
  input  logic                                  cfg_we,
  input  logic [tpspwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpspwm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                  out_valid,
  output logic [tpspwm_pkg::CMP_W-1:0]          out_compare_u,
  output logic [tpspwm_pkg::CMP_W-1:0]          out_compare_v,
  output logic [tpspwm_pkg::CMP_W-1:0]          out_compare_w
);

  localparam int unsigned SFB   = SINE_FRACTION_BITS;
  localparam int unsigned SH    = SFB + 1;
  localparam int unsigned PW    = tpspwm_pkg::MOD_W + SFB;
  localparam int unsigned SUMW  = PW + 1;
  localparam int unsigned QW    = SUMW - SH;
  localparam int unsigned DSHIFT = tpspwm_pkg::SINE_W - SFB;
  localparam logic [ANGLE_BITS-1:0] THIRD =
    ANGLE_BITS'(((1 << ANGLE_BITS) + 1) / 3);
  localparam logic [ANGLE_BITS-1:0] TWO_THIRDS =
    ANGLE_BITS'(((1 << (ANGLE_BITS + 1)) + 1) / 3);
  localparam logic [SUMW-1:0] ROUND_UP = SUMW'((1 << SH) - 1);
  localparam int unsigned NP = tpspwm_pkg::NPHASE;

  // configuration
  logic [tpspwm_pkg::MOD_W-1:0]    modulation_r;
  logic [tpspwm_pkg::PERIOD_W-1:0] period_r;
  logic                            busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulation_r <= tpspwm_pkg::MODULATION_RST;
      period_r     <= tpspwm_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpspwm_pkg::REG_MODULATION: begin
          modulation_r <= cfg_data;
        end
        tpspwm_pkg::REG_PERIOD_COUNTS: begin
          period_r <= cfg_data[tpspwm_pkg::PERIOD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end
  assign busy = busy_r;

  logic accept;
  assign accept = start && !busy_r;

  // stage 0: phase angles, quadrant fold, rom addresses
  logic [ANGLE_BITS-1:0]             ang;
  logic [ANGLE_BITS-1:0]             ph_ang   [NP];
  logic [15:0]                       a16      [NP];
  logic [14:0]                       off      [NP];
  logic [tpspwm_pkg::ROM_IDX_W-1:0]  idx0     [NP];
  logic [tpspwm_pkg::ROM_IDX_W-1:0]  idx1     [NP];

  assign ang = ANGLE_BITS'(in_angle);
  assign ph_ang[0] = ang;
  assign ph_ang[1] = ang + TWO_THIRDS;
  assign ph_ang[2] = ang + THIRD;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      a16[p] = 16'(ph_ang[p]) << (16 - ANGLE_BITS);
      off[p] = {1'b0, a16[p][13:0]};
      if (a16[p][14]) begin
        off[p] = 15'h4000 - off[p];
      end
      idx0[p] = off[p][14:8];
      idx1[p] = (idx0[p] == 7'd64) ? idx0[p] : idx0[p] + 7'd1;
    end
  end

  // stage 1: synchronous rom reads
  logic                    v1_r;
  tpspwm_pkg::sine_t       t0_r   [NP];
  tpspwm_pkg::sine_t       t1_r   [NP];
  logic [7:0]              frac1_r[NP];
  logic                    neg1_r [NP];

  always_ff @(posedge clk) begin
    for (int p = 0; p < NP; p++) begin
      t0_r[p]    <= tpspwm_pkg::QUARTER_SINE[idx0[p]];
      t1_r[p]    <= tpspwm_pkg::QUARTER_SINE[idx1[p]];
      frac1_r[p] <= off[p][7:0];
      neg1_r[p]  <= a16[p][15];
    end
  end

  // stage 2: linear interpolation
  logic [22:0]     ip_prod [NP];
  logic [22:0]     ip_rnd  [NP];
  logic [15:0]     mag_full[NP];
  logic            v2_r;
  logic [SFB-1:0]  mag2_r  [NP];
  logic            neg2_r  [NP];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      ip_prod[p]  = 23'(t1_r[p] - t0_r[p]) * 23'(frac1_r[p]);
      ip_rnd[p]   = ip_prod[p] + 23'd128;
      mag_full[p] = 16'(t0_r[p]) + 16'(ip_rnd[p][22:8]);
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NP; p++) begin
      mag2_r[p] <= SFB'(mag_full[p][14:0] >> DSHIFT);
      neg2_r[p] <= neg1_r[p];
    end
  end

  // stage 3: modulation multiply
  logic            v3_r;
  logic [PW-1:0]   mprod3_r[NP];
  logic            neg3_r  [NP];

  always_ff @(posedge clk) begin
    for (int p = 0; p < NP; p++) begin
      mprod3_r[p] <= PW'(modulation_r) * PW'(mag2_r[p]);
      neg3_r[p]   <= neg2_r[p];
    end
  end

  // stage 4: offset around midpoint and saturate
  logic [SUMW-1:0] qsum [NP];
  logic [QW-1:0]   qmag [NP];
  logic [QW+1:0]   dsum [NP];
  logic [tpspwm_pkg::PERIOD_W-1:0] duty_nxt[NP];
  logic            v4_r;
  logic [tpspwm_pkg::PERIOD_W-1:0] duty4_r[NP];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      qsum[p] = neg3_r[p] ? (SUMW'(mprod3_r[p]) + ROUND_UP) : SUMW'(mprod3_r[p]);
      qmag[p] = qsum[p][SUMW-1:SH];
      if (neg3_r[p]) begin
        dsum[p] = (QW+2)'(0);
        if ((QW+2)'(qmag[p]) > (QW+2)'(32768)) begin
          duty_nxt[p] = '0;
        end else begin
          duty_nxt[p] = tpspwm_pkg::PERIOD_W'(17'd32768 - tpspwm_pkg::PERIOD_W'(qmag[p]));
        end
      end else begin
        dsum[p] = (QW+2)'(qmag[p]) + (QW+2)'(32768);
        if (dsum[p] > (QW+2)'(65536)) begin
          duty_nxt[p] = tpspwm_pkg::FULL_SCALE;
        end else begin
          duty_nxt[p] = tpspwm_pkg::PERIOD_W'(dsum[p]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NP; p++) begin
      duty4_r[p] <= duty_nxt[p];
    end
  end

  // stage 5: scale onto the pwm period
  logic [tpspwm_pkg::PERIOD_W-1:0] period_sat;
  logic [33:0]                     cprod[NP];
  logic                            v5_r;
  logic [tpspwm_pkg::CMP_W-1:0]    cmp5_r[NP];

  assign period_sat = (period_r > tpspwm_pkg::FULL_SCALE) ? tpspwm_pkg::FULL_SCALE
                                                           : period_r;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      cprod[p] = 34'(duty4_r[p]) * 34'(period_sat);
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NP; p++) begin
      cmp5_r[p] <= cprod[p][32:16];
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_valid     = v5_r;
  assign out_compare_u = cmp5_r[0];
  assign out_compare_v = cmp5_r[1];
  assign out_compare_w = cmp5_r[2];

endmodule

### sim/tb.sv
// tb: self-checking testbench for three_phase_sine_pwm_compare
// predicts the u, v and w compare counts of every accepted angle word, checks each strobe
// depends on tpspwm_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;

  localparam int PIPE_LATENCY = 5;
  localparam int STALL_LIMIT = 2000;
  localparam int CHUNK_WORDS = 66;
  localparam int CHUNKS_PER_PROFILE = 8;
  localparam int TURN = 1 << tpspwm_pkg::IN_W;
  localparam int THIRD_TURN = (TURN + 1) / 3;
  localparam int TWO_THIRDS_TURN = (2 * TURN + 1) / 3;
  localparam int MOD_MAX = 131072;

  typedef struct packed {
    logic [tpspwm_pkg::CMP_W-1:0] u;
    logic [tpspwm_pkg::CMP_W-1:0] v;
    logic [tpspwm_pkg::CMP_W-1:0] w;
  } compare_set_t;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [tpspwm_pkg::IN_W-1:0]       in_angle;
  logic                              cfg_we;
  logic [tpspwm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tpspwm_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                              out_valid;
  logic [tpspwm_pkg::CMP_W-1:0]      out_compare_u;
  logic [tpspwm_pkg::CMP_W-1:0]      out_compare_v;
  logic [tpspwm_pkg::CMP_W-1:0]      out_compare_w;

  compare_set_t                      pending_compares[$];
  compare_set_t                      due_set;
  logic [tpspwm_pkg::MOD_W-1:0]      model_modulation;
  logic [tpspwm_pkg::PERIOD_W-1:0]   model_period;
  int                                words_sent;
  int                                results_seen;
  int                                cfg_writes;
  int                                n_err;
  int                                quiet_cycles;

  three_phase_sine_pwm_compare dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_angle      (in_angle),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_compare_u (out_compare_u),
    .out_compare_v (out_compare_v),
    .out_compare_w (out_compare_w)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // signed sine in q1.15, quarter-wave table with linear interpolation
  function automatic longint phase_sine(input logic [tpspwm_pkg::IN_W-1:0] ang);
    logic [15:0] a16;
    int          offs;
    int          idx;
    int          frac;
    longint      mag;
    longint      lo;
    longint      hi;
    a16 = 16'(ang) << (16 - tpspwm_pkg::IN_W);
    offs = int'(a16[13:0]);
    if (a16[14]) begin
      offs = 16384 - offs;
    end
    idx = offs >> 8;
    frac = offs & 255;
    if (idx >= 64) begin
      mag = longint'(tpspwm_pkg::QUARTER_SINE[64]);
    end else begin
      lo = longint'(tpspwm_pkg::QUARTER_SINE[idx]);
      hi = longint'(tpspwm_pkg::QUARTER_SINE[idx + 1]);
      mag = lo + (((hi - lo) * frac + 128) >>> 8);
    end
    return a16[15] ? -mag : mag;
  endfunction

  function automatic logic [tpspwm_pkg::CMP_W-1:0] phase_compare(
    input logic [tpspwm_pkg::IN_W-1:0] ang,
    input longint per
  );
    longint term;
    longint duty;
    term = (longint'(model_modulation) * phase_sine(ang)) >>> 16;
    duty = 32768 + term;
    if (duty < 0) begin
      duty = 0;
    end
    if (duty > longint'(tpspwm_pkg::FULL_SCALE)) begin
      duty = longint'(tpspwm_pkg::FULL_SCALE);
    end
    return tpspwm_pkg::CMP_W'((duty * per) >> 16);
  endfunction

  function automatic compare_set_t predict_compares(input logic [tpspwm_pkg::IN_W-1:0] ang);
    compare_set_t cs;
    longint       per;
    per = longint'(model_period);
    if (per > longint'(tpspwm_pkg::FULL_SCALE)) begin
      per = longint'(tpspwm_pkg::FULL_SCALE);
    end
    cs.u = phase_compare(ang, per);
    cs.v = phase_compare(ang + tpspwm_pkg::IN_W'(TWO_THIRDS_TURN), per);
    cs.w = phase_compare(ang + tpspwm_pkg::IN_W'(THIRD_TURN), per);
    return cs;
  endfunction

  task automatic check_field(input string fname, input logic [tpspwm_pkg::CMP_W-1:0] want,
                             input logic [tpspwm_pkg::CMP_W-1:0] got);
    if (got !== want) begin
      n_err++;
      if (n_err <= 40) begin
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      end
    end
  endtask

  // check first, then predict from the settings in force at this edge, then take any write
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      results_seen++;
      if (pending_compares.size() == 0) begin
        n_err++;
        if (n_err <= 40) begin
          $display("%0t ns: result with no word waiting, expected none, got %0d %0d %0d",
                   $time, out_compare_u, out_compare_v, out_compare_w);
        end
      end else begin
        due_set = pending_compares.pop_front();
        check_field("compare_u", due_set.u, out_compare_u);
        check_field("compare_v", due_set.v, out_compare_v);
        check_field("compare_w", due_set.w, out_compare_w);
      end
    end
    if (rst_n && start && !busy) begin
      pending_compares.push_back(predict_compares(in_angle));
    end
    if (rst_n && cfg_we) begin
      case (cfg_index)
        tpspwm_pkg::REG_MODULATION: begin
          model_modulation = cfg_data[tpspwm_pkg::MOD_W-1:0];
        end
        tpspwm_pkg::REG_PERIOD_COUNTS: begin
          model_period = cfg_data[tpspwm_pkg::PERIOD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no word accepted for %0d cycles", $time, STALL_LIMIT);
      $display("three_phase_sine_pwm_compare regression: fail");
      $finish;
    end
  end

  task automatic send_angle(input logic [tpspwm_pkg::IN_W-1:0] ang, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) begin
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_angle <= ang;
    do begin
      @(posedge clk);
    end while (busy);
    words_sent++;
  endtask

  // hold off until every word has come back, then let the pipeline settle
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (results_seen < words_sent) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tpspwm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tpspwm_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  function automatic logic [tpspwm_pkg::CFG_DATA_W-1:0] pick_modulation();
    case ($urandom_range(9))
      0: return '0;
      1: return tpspwm_pkg::CFG_DATA_W'(MOD_MAX);
      2: return tpspwm_pkg::CFG_DATA_W'($urandom_range(MOD_MAX + 1,
                                                       (1 << tpspwm_pkg::MOD_W) - 1));
      3: return tpspwm_pkg::CFG_DATA_W'($urandom_range(0, (1 << tpspwm_pkg::MOD_W) - 1));
      default: return tpspwm_pkg::CFG_DATA_W'($urandom_range(0, MOD_MAX));
    endcase
  endfunction

  function automatic logic [tpspwm_pkg::CFG_DATA_W-1:0] pick_period();
    case ($urandom_range(11))
      0: return '0;
      1: return tpspwm_pkg::CFG_DATA_W'(1);
      2: return tpspwm_pkg::CFG_DATA_W'(tpspwm_pkg::FULL_SCALE);
      3: return tpspwm_pkg::CFG_DATA_W'($urandom_range(tpspwm_pkg::FULL_SCALE + 1,
                                                       (1 << tpspwm_pkg::CFG_DATA_W) - 1));
      default: return tpspwm_pkg::CFG_DATA_W'($urandom_range(1, tpspwm_pkg::FULL_SCALE));
    endcase
  endfunction

  // mostly uniform, sometimes close to a quadrant boundary
  function automatic logic [tpspwm_pkg::IN_W-1:0] pick_angle();
    if ($urandom_range(7) == 0) begin
      return tpspwm_pkg::IN_W'(($urandom_range(3) << (tpspwm_pkg::IN_W - 2))
                               + $urandom_range(4) - 2);
    end
    return tpspwm_pkg::IN_W'($urandom_range(0, TURN - 1));
  endfunction

  task automatic test_reset_defaults();
    send_angle('0, 0);
    send_angle('1, 0);
    send_angle(tpspwm_pkg::IN_W'(TURN / 4), 0);
    send_angle(tpspwm_pkg::IN_W'(TURN / 2), 0);
    send_angle(tpspwm_pkg::IN_W'(3 * TURN / 4), 0);
    send_angle(tpspwm_pkg::IN_W'(THIRD_TURN), 0);
    send_angle(tpspwm_pkg::IN_W'(TWO_THIRDS_TURN), 0);
    send_angle(tpspwm_pkg::IN_W'(TWO_THIRDS_TURN - 1), 0);
    drain_results();
  endtask

  // zero depth, unity, full over-modulation and a depth beyond the nominal range
  task automatic test_modulation_extremes();
    logic [tpspwm_pkg::CFG_DATA_W-1:0] depths[4];
    depths = '{'0, tpspwm_pkg::CFG_DATA_W'(65536), tpspwm_pkg::CFG_DATA_W'(MOD_MAX), '1};
    foreach (depths[k]) begin
      write_reg(tpspwm_pkg::REG_MODULATION, depths[k]);
      send_angle(tpspwm_pkg::IN_W'(TURN / 4), 0);
      send_angle(tpspwm_pkg::IN_W'(3 * TURN / 4), 0);
      drain_results();
    end
  endtask

  // zero period, minimum, full scale, and a value above full scale with the top data bit set
  task automatic test_period_extremes();
    logic [tpspwm_pkg::CFG_DATA_W-1:0] periods[4];
    periods = '{'0, tpspwm_pkg::CFG_DATA_W'(1),
                tpspwm_pkg::CFG_DATA_W'(tpspwm_pkg::FULL_SCALE), '1};
    write_reg(tpspwm_pkg::REG_MODULATION, tpspwm_pkg::CFG_DATA_W'(65536));
    foreach (periods[k]) begin
      write_reg(tpspwm_pkg::REG_PERIOD_COUNTS, periods[k]);
      send_angle(tpspwm_pkg::IN_W'(TURN / 4), 0);
      send_angle(tpspwm_pkg::IN_W'(3 * TURN / 4), 0);
      drain_results();
    end
  endtask

  task automatic test_random_stream(input int idle_pct);
    repeat (CHUNKS_PER_PROFILE) begin
      write_reg(tpspwm_pkg::REG_MODULATION, pick_modulation());
      write_reg(tpspwm_pkg::REG_PERIOD_COUNTS, pick_period());
      repeat (CHUNK_WORDS) send_angle(pick_angle(), idle_pct);
      drain_results();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_angle <= '0;
    cfg_we <= 1'b0;
    cfg_index <= tpspwm_pkg::REG_MODULATION;
    cfg_data <= '0;
    model_modulation = tpspwm_pkg::MODULATION_RST;
    model_period = tpspwm_pkg::PERIOD_RST;
    words_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    n_err = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_modulation_extremes();
    test_period_extremes();
    test_random_stream(7);
    test_random_stream(60);
    test_random_stream(0);
    drain_results();

    if (pending_compares.size() != 0) begin
      n_err++;
      $display("%0t ns: words left without a result, expected 0, got %0d",
               $time, pending_compares.size());
    end
    $display("run covered %0d angle words and %0d checked results", words_sent, results_seen);
    $display("over %0d register writes and three sender idle profiles", cfg_writes);
    if (n_err == 0) begin
      $display("three_phase_sine_pwm_compare regression: pass");
    end else begin
      $display("three_phase_sine_pwm_compare regression: fail");
    end
    $finish;
  end

endmodule
